// File: rtl/weight_stationary_conv_window_mac_core_defines.svh
// Assertion macros for the weight-stationary convolution window MAC core.
`ifndef WEIGHT_STATIONARY_CONV_WINDOW_MAC_CORE_DEFINES_SVH
`define WEIGHT_STATIONARY_CONV_WINDOW_MAC_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check that cons holds in the cycle after ante.
`define WSCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wscw: next-cycle check failed");
// Check that cons holds in the same cycle as ante.
`define WSCW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wscw: same-cycle check failed");
`else
`define WSCW_ASSERT_NEXT(label, ante, cons)
`define WSCW_ASSERT_SAME(label, ante, cons)
`endif
`endif

// File: rtl/wscw_pkg.sv
// Shared constants and types for the weight-stationary convolution window MAC core.
`default_nettype none
package wscw_pkg;

    // Default array shape: 16 channels of a 3x3 kernel.
    localparam int unsigned CHANNEL_GROUP_DEF = 16;
    localparam int unsigned KERNEL_SIDE_DEF   = 3;

    // Item field widths.
    localparam int unsigned TAP_IDX_W  = 8;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned POS_W      = 12;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned PROD_W     = 2 * DATA_W;
    localparam int unsigned ACC_W      = 23;

    // Input tdata layout, lowest field first.
    localparam int unsigned TAP_IDX_LSB = 0;
    localparam int unsigned DATA_LSB    = TAP_IDX_LSB + TAP_IDX_W;
    localparam int unsigned ROW_LSB     = DATA_LSB + DATA_W;
    localparam int unsigned COL_LSB     = ROW_LSB + POS_W;
    localparam int unsigned PRIOR_LSB   = COL_LSB + POS_W;
    localparam int unsigned S_TDATA_W   = PRIOR_LSB + SUM_W;

    // Configuration registers.
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 13;
    localparam logic [CFG_DATA_W-1:0] IMAGE_SIZE_RST = CFG_DATA_W'(112);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_HEIGHT = 1'b0,
        CFG_IMAGE_WIDTH  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        FUNC_LOAD_WEIGHT = 1'b0,
        FUNC_FEATURE     = 1'b1
    } func_t;

endpackage
`default_nettype wire

// File: rtl/weight_stationary_conv_window_mac_core.sv
// Weight-stationary 3x3 convolution window multiply-accumulate core, top level.
//
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | s_tdata: tap_index, data_byte, out_row, out_col,
//         |     |                    | prior_sum; s_tuser: func; s_tlast: last
// m_      | out | m_tvalid/m_tready  | m_tdata: pixel_sum
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (image_height, image_width)
//
// One item is accepted per cycle while s_tready is high: each needs one weight access and at most one multiply.
// A feature item reads its weight as it is accepted, is multiplied and padding-checked in
// stage 1 and accumulated in stage 2; a last element in stage 2 sets the registered m_tvalid.
// Reset (aresetn low, synchronous) empties the pipeline, clears the accumulator and
// restores the image size to 112x112; the weight memory is not cleared.
// A waiting result holds only a closing element in stage 2; stage 1 takes one more item.
`default_nettype none
`include "weight_stationary_conv_window_mac_core_defines.svh"
module weight_stationary_conv_window_mac_core #(
    parameter int unsigned CHANNEL_GROUP = wscw_pkg::CHANNEL_GROUP_DEF,
    parameter int unsigned KERNEL_SIDE   = wscw_pkg::KERNEL_SIDE_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input item stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [7:0] tap_index, [15:8] data_byte, [27:16] out_row, [39:28] out_col,
    // [71:40] prior_sum
    input  wire logic [wscw_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] func
    input  wire logic                                s_tuser,
    input  wire logic                                s_tlast,
    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [31:0] pixel_sum
    output logic [wscw_pkg::SUM_W-1:0]               m_tdata,
    // Configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [wscw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [wscw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned TAPS_PER_CH = KERNEL_SIDE * KERNEL_SIDE;
    localparam int unsigned STORE_FULL  = CHANNEL_GROUP * TAPS_PER_CH;
    localparam int unsigned TAB_DEPTH   = 2 ** wscw_pkg::TAP_IDX_W;
    // Only entries reachable by an 8-bit index are stored.
    localparam int unsigned MEM_DEPTH   = (STORE_FULL < TAB_DEPTH) ? STORE_FULL : TAB_DEPTH;
    localparam int unsigned MEM_AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int unsigned KW          = (KERNEL_SIDE > 1) ? $clog2(KERNEL_SIDE) : 1;
    localparam int unsigned IDX_CMP_W   = wscw_pkg::TAP_IDX_W + 1;
    localparam int unsigned SUM_POS_W   = wscw_pkg::POS_W + 2;

    // ------------------------------------------------------------------
    // Unpack the input item
    // ------------------------------------------------------------------
    logic [wscw_pkg::TAP_IDX_W-1:0]    in_tap_index;
    logic signed [wscw_pkg::DATA_W-1:0] in_data_byte;
    logic [wscw_pkg::POS_W-1:0]        in_out_row;
    logic [wscw_pkg::POS_W-1:0]        in_out_col;
    logic signed [wscw_pkg::SUM_W-1:0] in_prior_sum;
    logic                              in_accept;
    logic                              in_is_feature;
    logic                              in_idx_ok;

    assign in_tap_index = s_tdata[wscw_pkg::TAP_IDX_LSB +: wscw_pkg::TAP_IDX_W];
    assign in_data_byte = s_tdata[wscw_pkg::DATA_LSB +: wscw_pkg::DATA_W];
    assign in_out_row   = s_tdata[wscw_pkg::ROW_LSB +: wscw_pkg::POS_W];
    assign in_out_col   = s_tdata[wscw_pkg::COL_LSB +: wscw_pkg::POS_W];
    assign in_prior_sum = s_tdata[wscw_pkg::PRIOR_LSB +: wscw_pkg::SUM_W];

    assign in_accept     = s_tvalid && s_tready;
    assign in_is_feature = (wscw_pkg::func_t'(s_tuser) == wscw_pkg::FUNC_FEATURE);
    assign in_idx_ok     = ({1'b0, in_tap_index} < IDX_CMP_W'(MEM_DEPTH));

    // ------------------------------------------------------------------
    // Kernel row and column of every index, fixed at elaboration
    // ------------------------------------------------------------------
    logic [KW-1:0] kr_tab [TAB_DEPTH];
    logic [KW-1:0] kc_tab [TAB_DEPTH];

    for (genvar gi = 0; gi < TAB_DEPTH; gi++) begin : g_tap_tab
        localparam int unsigned Within = gi % TAPS_PER_CH;
        assign kr_tab[gi] = KW'(Within / KERNEL_SIDE);
        assign kc_tab[gi] = KW'(Within % KERNEL_SIDE);
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [wscw_pkg::CFG_DATA_W-1:0] image_height_reg, image_height_next;
    logic [wscw_pkg::CFG_DATA_W-1:0] image_width_reg, image_width_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        image_height_next = image_height_reg;
        image_width_next  = image_width_reg;
        if (cfg_valid) begin
            unique case (wscw_pkg::cfg_reg_t'(cfg_index))
                wscw_pkg::CFG_IMAGE_HEIGHT: image_height_next = cfg_data;
                wscw_pkg::CFG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_height_reg <= wscw_pkg::IMAGE_SIZE_RST;
            image_width_reg  <= wscw_pkg::IMAGE_SIZE_RST;
        end else begin
            image_height_reg <= image_height_next;
            image_width_reg  <= image_width_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control: a stage moves on when the one after it has room.
    // Only a last feature element needs the output register.
    // ------------------------------------------------------------------
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic last2_reg;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_room;
    logic fire1;
    logic fire2;
    logic s2_room;

    assign out_room = !m_tvalid_reg || m_tready;
    assign fire2    = v2_reg && (!last2_reg || out_room);
    assign s2_room  = !v2_reg || fire2;
    assign fire1    = v1_reg && s2_room;
    assign s_tready = !v1_reg || s2_room;

    // ------------------------------------------------------------------
    // Weight memory: write on a load item, read on a feature item
    // ------------------------------------------------------------------
    logic signed [wscw_pkg::DATA_W-1:0] weight_mem [MEM_DEPTH];
    logic signed [wscw_pkg::DATA_W-1:0] weight_rd_reg;

    always_ff @(posedge aclk) begin
        if (in_accept && !in_is_feature && in_idx_ok) begin
            weight_mem[in_tap_index[MEM_AW-1:0]] <= in_data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && in_is_feature && in_idx_ok) begin
            weight_rd_reg <= weight_mem[in_tap_index[MEM_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: feature item with its weight; multiply and padding check
    // ------------------------------------------------------------------
    logic signed [wscw_pkg::DATA_W-1:0] data1_reg;
    logic [wscw_pkg::POS_W-1:0]         row1_reg;
    logic [wscw_pkg::POS_W-1:0]         col1_reg;
    logic [KW-1:0]                      kr1_reg;
    logic [KW-1:0]                      kc1_reg;
    logic                               idx_ok1_reg;
    logic signed [wscw_pkg::SUM_W-1:0]  prior1_reg;
    logic                               last1_reg;

    // Load items stop here; only feature items enter stage 1.
    always_comb begin
        v1_next = v1_reg;
        if (s_tready) begin
            v1_next = in_accept && in_is_feature;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && in_is_feature) begin
            data1_reg   <= in_data_byte;
            row1_reg    <= in_out_row;
            col1_reg    <= in_out_col;
            kr1_reg     <= kr_tab[in_tap_index];
            kc1_reg     <= kc_tab[in_tap_index];
            idx_ok1_reg <= in_idx_ok;
            prior1_reg  <= in_prior_sum;
            last1_reg   <= s_tlast;
        end
    end

    // Input position = output position + kernel offset - 1 (padding 1).
    // Inside means 1 <= pos + offset <= image size.
    logic [SUM_POS_W-1:0]                row_sum;
    logic [SUM_POS_W-1:0]                col_sum;
    logic                                tap_inside;
    logic signed [wscw_pkg::PROD_W-1:0]  prod1;
    logic signed [wscw_pkg::PROD_W-1:0]  prod1_eff;

    assign row_sum    = SUM_POS_W'(row1_reg) + SUM_POS_W'(kr1_reg);
    assign col_sum    = SUM_POS_W'(col1_reg) + SUM_POS_W'(kc1_reg);
    assign tap_inside = (row_sum != '0) && (row_sum <= SUM_POS_W'(image_height_reg)) &&
                        (col_sum != '0) && (col_sum <= SUM_POS_W'(image_width_reg));
    assign prod1      = data1_reg * weight_rd_reg;
    // Drop taps that fall in the padding or past the store.
    assign prod1_eff  = (idx_ok1_reg && tap_inside) ? prod1 : '0;

    // ------------------------------------------------------------------
    // Stage 2: accumulate; on the last element add the prior sum and emit
    // ------------------------------------------------------------------
    logic signed [wscw_pkg::PROD_W-1:0] prod2_reg;
    logic signed [wscw_pkg::SUM_W-1:0]  prior2_reg;

    always_comb begin
        v2_next = v2_reg;
        if (s2_room) begin
            v2_next = fire1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire1) begin
            prod2_reg  <= prod1_eff;
            prior2_reg <= prior1_reg;
            last2_reg  <= last1_reg;
        end
    end

    logic signed [wscw_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic signed [wscw_pkg::ACC_W-1:0] acc_sum;
    logic signed [wscw_pkg::SUM_W-1:0] pixel_sum;
    logic [wscw_pkg::SUM_W-1:0]        m_tdata_reg, m_tdata_next;

    // Accumulator wraps at its own width; the total wraps at 32 bits.
    assign acc_sum   = acc_reg + wscw_pkg::ACC_W'(prod2_reg);
    assign pixel_sum = wscw_pkg::SUM_W'(acc_sum) + prior2_reg;

    always_comb begin
        acc_next      = acc_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (fire2) begin
            if (last2_reg) begin
                acc_next      = '0;
                m_tdata_next  = pixel_sum;
                m_tvalid_next = 1'b1;
            end else begin
                acc_next = acc_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            acc_reg      <= acc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A window that closes always leaves a result in the output register.
    `WSCW_ASSERT_NEXT(a_close_emits, v2_reg && last2_reg && out_room, m_tvalid_reg)
    // Closing a window leaves the accumulator clear for the next one.
    `WSCW_ASSERT_NEXT(a_close_clears, v2_reg && last2_reg && out_room, acc_reg == '0)
    // A weight load never enters the compute stages.
    `WSCW_ASSERT_NEXT(a_load_no_stage, in_accept && !in_is_feature, !v1_reg)
    // Input backpressure comes only from a result waiting downstream.
    `WSCW_ASSERT_SAME(a_stall_cause, !s_tready, m_tvalid && !m_tready && v1_reg && v2_reg)

endmodule
`default_nettype wire
